>>> rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int ADDR_W = 11;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = ATTR_W + CHAR_W;

	localparam logic [ADDR_W-1:0] CELL_LAST     = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STEP      = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(COLUMNS - 1);

	localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_ADV,
		CUR_BACK,
		CUR_NEWLINE,
		CUR_HOME,
		CUR_LASTROW
	} cur_op_t;

	typedef struct packed {
		logic [ADDR_W-1:0] cursor;
		logic              at_home;
		logic              at_last_cell;
		logic              on_last_row;
	} cur_stat_t;

	typedef struct packed {
		logic go;
		logic scroll;
	} sweep_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sweep_stat_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
		input logic [CHAR_W-1:0] ch);
		return {attr, ch};
	endfunction

endpackage

`default_nettype wire

>>> rtl/text_console_writer.sv
// Channel   | Signals                                  | Handshake
// ----------+------------------------------------------+------------------------------
// request   | opcode, char_code, cell_address          | start && !busy
// result    | cell_data, cursor_now, scrolled          | done, one cycle, no back-pressure
// config    | cfg_data (text attribute)                | cfg_valid && cfg_ready
//
// Character write, newline, backspace, read and no-op pass through S_EXEC and
// return to S_IDLE, unless a newline on the last row or a character on the last
// cell starts a scroll; the result shows in the cycle after the request is handled.
// Clear and scroll walk the whole screen memory one cell per cycle through its
// single write port. After reset the block blanks the screen memory and stays busy meanwhile.
// done is a one-cycle strobe; the receiver cannot stall it.
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        opcode,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [ADDR_W-1:0] cell_address,
	output logic                   done,
	output logic      [CELL_W-1:0] cell_data,
	output logic      [ADDR_W-1:0] cursor_now,
	output logic                   scrolled,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [ATTR_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_EXEC  = 3'b010,
		S_SWEEP = 3'b100
	} state_t;

	state_t            state_q;
	logic [ATTR_W-1:0] attr_q;
	op_t               op_q;
	logic [CHAR_W-1:0] chr_q;
	logic              rd_ok_q;
	logic              respond_q;
	logic              scroll_pend_q;
	logic              done_q;
	logic [CELL_W-1:0] cell_data_q;
	logic [ADDR_W-1:0] cursor_now_q;
	logic              scrolled_q;

	logic              accept;
	logic              req_rd_ok;
	cur_op_t           cur_cmd;
	cur_stat_t         cur_stat;
	logic [ADDR_W-1:0] cursor_nxt;
	sweep_cmd_t        sweep_cmd;
	sweep_stat_t       sweep_stat;
	mem_rd_t           sweep_rd;
	mem_wr_t           sweep_wr;
	mem_wr_t           exec_wr;
	mem_wr_t           ram_wr;
	mem_rd_t           ram_rd;
	logic [CELL_W-1:0] ram_rdata;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign req_rd_ok = (op_t'(opcode) == OP_READ) && (cell_address <= CELL_LAST);

	// read for a cell request is issued at acceptance, data ready in S_EXEC
	assign ram_rd.en   = sweep_rd.en || (accept && req_rd_ok);
	assign ram_rd.addr = sweep_rd.en ? sweep_rd.addr : cell_address;
	assign ram_wr      = sweep_wr.en ? sweep_wr : exec_wr;

	always_comb begin
		cur_cmd          = CUR_HOLD;
		exec_wr.en       = 1'b0;
		exec_wr.addr     = cur_stat.cursor;
		exec_wr.data     = make_cell(attr_q, CH_SPACE);
		sweep_cmd.go     = 1'b0;
		sweep_cmd.scroll = 1'b0;
		if (state_q == S_EXEC) begin
			case (op_q)
				OP_WRITE: begin
					if (chr_q == CH_NEWLINE) begin
						if (cur_stat.on_last_row) begin
							cur_cmd          = CUR_LASTROW;
							sweep_cmd.go     = 1'b1;
							sweep_cmd.scroll = 1'b1;
						end else begin
							cur_cmd = CUR_NEWLINE;
						end
					end else if (chr_q == CH_BACKSPACE) begin
						if (!cur_stat.at_home) begin
							cur_cmd      = CUR_BACK;
							exec_wr.en   = 1'b1;
							exec_wr.addr = cur_stat.cursor - ADDR_W'(1);
						end
					end else if (chr_q != CH_NUL) begin
						exec_wr.en   = 1'b1;
						exec_wr.data = make_cell(attr_q, chr_q);
						if (cur_stat.at_last_cell) begin
							// char lands first, then the scroll moves it up a row
							cur_cmd          = CUR_LASTROW;
							sweep_cmd.go     = 1'b1;
							sweep_cmd.scroll = 1'b1;
						end else begin
							cur_cmd = CUR_ADV;
						end
					end
				end
				OP_CLEAR: begin
					cur_cmd      = CUR_HOME;
					sweep_cmd.go = 1'b1;
				end
				default: begin
					cur_cmd = CUR_HOLD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			respond_q     <= 1'b0;
			scroll_pend_q <= 1'b0;
			done_q        <= 1'b0;
			attr_q        <= RESET_ATTR;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (sweep_cmd.go) begin
						state_q       <= S_SWEEP;
						respond_q     <= 1'b1;
						scroll_pend_q <= sweep_cmd.scroll;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_SWEEP: begin
					if (sweep_stat.done) begin
						state_q   <= S_IDLE;
						done_q    <= respond_q;
						respond_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(opcode);
			chr_q   <= char_code;
			rd_ok_q <= req_rd_ok;
		end
		if (state_q == S_EXEC && !sweep_cmd.go) begin
			cell_data_q  <= rd_ok_q ? ram_rdata : '0;
			cursor_now_q <= cursor_nxt;
			scrolled_q   <= 1'b0;
		end else if (state_q == S_SWEEP && sweep_stat.done) begin
			cell_data_q  <= '0;
			cursor_now_q <= cur_stat.cursor;
			scrolled_q   <= scroll_pend_q;
		end
	end

	assign done       = done_q;
	assign cell_data  = cell_data_q;
	assign cursor_now = cursor_now_q;
	assign scrolled   = scrolled_q;

	tcw_cursor u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cur_cmd),
		.stat       (cur_stat),
		.cursor_nxt (cursor_nxt)
	);

	tcw_sweep u_sweep (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (sweep_cmd),
		.attr    (attr_q),
		.rd_data (ram_rdata),
		.rd      (sweep_rd),
		.wr      (sweep_wr),
		.stat    (sweep_stat)
	);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_rd.en),
		.raddr (ram_rd.addr),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_stat.cursor <= CELL_LAST)
		else $error("cursor beyond screen end");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_wr.en)
		else $error("screen write while idle");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && scrolled_q) |-> (cursor_now_q == LAST_ROW_BASE))
		else $error("scroll result with cursor off last row start");

	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q == S_EXEC) || $past(sweep_stat.done)))
		else $error("result strobe without finished request");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while busy");
`endif

endmodule

`default_nettype wire

>>> rtl/tcw_ram.sv
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/tcw_cursor.sv
`default_nettype none

module tcw_cursor
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cur_op_t           cmd,
	output cur_stat_t              stat,
	output logic      [ADDR_W-1:0] cursor_nxt
);

	logic [ADDR_W-1:0] cursor_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  col_nxt;

	// column tracked alongside the linear cursor so newline needs no modulo
	always_comb begin
		cursor_nxt = cursor_q;
		col_nxt    = col_q;
		case (cmd)
			CUR_ADV: begin
				cursor_nxt = cursor_q + ADDR_W'(1);
				col_nxt    = (col_q == COL_LAST) ? '0 : col_q + COL_W'(1);
			end
			CUR_BACK: begin
				cursor_nxt = cursor_q - ADDR_W'(1);
				col_nxt    = (col_q == '0) ? COL_LAST : col_q - COL_W'(1);
			end
			CUR_NEWLINE: begin
				cursor_nxt = cursor_q - ADDR_W'(col_q) + ROW_STEP;
				col_nxt    = '0;
			end
			CUR_HOME: begin
				cursor_nxt = '0;
				col_nxt    = '0;
			end
			CUR_LASTROW: begin
				cursor_nxt = LAST_ROW_BASE;
				col_nxt    = '0;
			end
			default: begin
				cursor_nxt = cursor_q;
				col_nxt    = col_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q    <= '0;
		end else begin
			cursor_q <= cursor_nxt;
			col_q    <= col_nxt;
		end
	end

	assign stat.cursor       = cursor_q;
	assign stat.at_home      = (cursor_q == '0);
	assign stat.at_last_cell = (cursor_q == CELL_LAST);
	assign stat.on_last_row  = (cursor_q >= LAST_ROW_BASE);

endmodule

`default_nettype wire

>>> rtl/tcw_sweep.sv
`default_nettype none

module tcw_sweep
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sweep_cmd_t        cmd,
	input  wire logic [ATTR_W-1:0] attr,
	input  wire logic [CELL_W-1:0] rd_data,
	output mem_rd_t                rd,
	output mem_wr_t                wr,
	output sweep_stat_t            stat
);

	logic              active_q;
	logic              scroll_q;
	logic              init_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              wvld_s1;
	logic              wcopy_s1;
	logic [ADDR_W-1:0] waddr_s1;
	logic [CELL_W-1:0] blank;

	// one cell per cycle: when scrolling, read the row below and write it back in the next cycle
	assign rd.en   = active_q && scroll_q && (cnt_q < LAST_ROW_BASE);
	assign rd.addr = cnt_q + ROW_STEP;

	assign blank   = init_q ? make_cell(RESET_ATTR, CH_SPACE) : make_cell(attr, CH_SPACE);
	assign wr.en   = wvld_s1;
	assign wr.addr = waddr_s1;
	assign wr.data = wcopy_s1 ? rd_data : blank;

	assign stat.busy = active_q || wvld_s1;
	assign stat.done = wvld_s1 && !active_q;

	// comes out of reset walking the screen to blank it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			scroll_q <= 1'b0;
			init_q   <= 1'b1;
			cnt_q    <= '0;
			wvld_s1  <= 1'b0;
		end else begin
			wvld_s1 <= active_q;
			if (active_q) begin
				cnt_q <= cnt_q + ADDR_W'(1);
				if (cnt_q == CELL_LAST) begin
					active_q <= 1'b0;
				end
			end else if (cmd.go) begin
				active_q <= 1'b1;
				scroll_q <= cmd.scroll;
				cnt_q    <= '0;
			end
			if (stat.done) begin
				init_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wcopy_s1 <= rd.en;
		waddr_s1 <= cnt_q;
	end

endmodule

`default_nettype wire

>>> tb/tcw_tb_pkg.sv
package tcw_tb_pkg;

	import tcw_pkg::*;

	typedef struct packed {
		logic [CELL_W-1:0] cell_val;
		logic [ADDR_W-1:0] cursor;
		logic              scroll;
	} console_reply_t;

	// Shadow copy of the screen and cursor; every accepted request queues the reply it is due.
	class screen_shadow;
		logic [CELL_W-1:0] cells [CELL_COUNT];
		int                cursor;
		logic [ATTR_W-1:0] attr;
		console_reply_t    due_replies [$];
		int                faults;

		function new();
			attr   = RESET_ATTR;
			faults = 0;
			blank_screen();
		endfunction

		function void blank_screen();
			foreach (cells[i])
				cells[i] = {attr, CH_SPACE};
			cursor = 0;
		endfunction

		function void set_attribute(logic [ATTR_W-1:0] value);
			attr = value;
		endfunction

		function int pending();
			return due_replies.size();
		endfunction

		function void note_request(op_t op, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr);
			console_reply_t r;
			r = '0;
			case (op)
				OP_WRITE: begin
					if (ch == CH_NEWLINE)
						cursor += COLUMNS - (cursor % COLUMNS);
					else if (ch == CH_BACKSPACE) begin
						if (cursor > 0) begin
							cursor--;
							cells[cursor] = {attr, CH_SPACE};
						end
					end else if (ch != CH_NUL) begin
						cells[cursor] = {attr, ch};
						cursor++;
					end
					if (cursor >= CELL_COUNT) begin
						for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
							cells[i] = cells[i + COLUMNS];
						for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
							cells[i] = {attr, CH_SPACE};
						cursor   = CELL_COUNT - COLUMNS;
						r.scroll = 1'b1;
					end
				end
				OP_CLEAR: blank_screen();
				OP_READ: begin
					if (addr < CELL_COUNT)
						r.cell_val = cells[addr];
				end
				default: ;
			endcase
			r.cursor = ADDR_W'(cursor);
			due_replies.push_back(r);
		endfunction

		function void note_fault(string msg);
			faults++;
			if (faults <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_reply(console_reply_t got);
			console_reply_t exp;
			if (due_replies.size() == 0) begin
				note_fault($sformatf("unexpected reply: cell %h cursor %0d scrolled %b",
					got.cell_val, got.cursor, got.scroll));
				return;
			end
			exp = due_replies.pop_front();
			if (got !== exp)
				note_fault($sformatf("reply: cell %h/%h cursor %0d/%0d scrolled %b/%b (exp/got)",
					exp.cell_val, got.cell_val, exp.cursor, got.cursor, exp.scroll, got.scroll));
		endfunction

		function void close();
			if (due_replies.size() != 0)
				note_fault($sformatf("%0d replies never arrived", due_replies.size()));
		endfunction
	endclass

endpackage

>>> tb/tb_text_console_writer.sv
module tb_text_console_writer;

	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;
	import tcw_tb_pkg::*;

	localparam int     CLK_PERIOD   = 12;
	localparam int     PHASE_ITEMS  = 305;
	// every request a full-screen sweep plus the longest gap, four times over
	localparam longint LIMIT_CYCLES = 64'd4 * 1900 * (CELL_COUNT + 40) + 4 * CELL_COUNT;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        opcode;
	logic [CHAR_W-1:0] char_code;
	logic [ADDR_W-1:0] cell_address;
	logic              done;
	logic [CELL_W-1:0] cell_data;
	logic [ADDR_W-1:0] cursor_now;
	logic              scrolled;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [ATTR_W-1:0] cfg_data;

	screen_shadow shadow;
	int           burst_left = 0;
	int           text_run = 0;

	text_console_writer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.char_code    (char_code),
		.cell_address (cell_address),
		.done         (done),
		.cell_data    (cell_data),
		.cursor_now   (cursor_now),
		.scrolled     (scrolled),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			shadow.check_reply(console_reply_t'({cell_data, cursor_now, scrolled}));
	end

	task automatic pause_requests();
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic issue(op_t op, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr);
		@(negedge clk);
		start        = 1'b1;
		opcode       = op;
		char_code    = ch;
		cell_address = addr;
		@(posedge clk);
		while (busy) @(posedge clk);
		shadow.note_request(op, ch, addr);
		if (burst_left > 0)
			burst_left--;
		else begin
			@(negedge clk);
			start        = 1'b0;
			opcode       = 2'($urandom);
			char_code    = CHAR_W'($urandom);
			cell_address = ADDR_W'($urandom);
			repeat ($urandom_range(0, 11)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	// only once every reply is in and the block has gone idle
	task automatic set_attribute(logic [ATTR_W-1:0] value);
		pause_requests();
		while (shadow.pending() != 0) @(posedge clk);
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow.set_attribute(value);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = ATTR_W'($urandom);
	endtask

	task automatic directed_requests();
		issue(OP_READ, CH_NUL, 11'd0);
		issue(OP_READ, CH_NUL, 11'd1999);
		issue(OP_READ, 8'hFF, 11'd2000);          // past the screen end
		issue(OP_READ, CH_NUL, 11'h7FF);
		issue(OP_WRITE, CH_NUL, 11'd0);           // zero byte, ignored
		issue(OP_WRITE, CH_BACKSPACE, 11'd0);     // backspace at home
		issue(OP_WRITE, 8'hFF, 11'h7FF);
		issue(OP_WRITE, 8'h80, 11'd0);
		issue(OP_WRITE, 8'h41, 11'd0);
		issue(OP_WRITE, CH_BACKSPACE, 11'd0);
		issue(OP_WRITE, CH_NEWLINE, 11'd0);
		issue(OP_WRITE, 8'h01, 11'd0);
		issue(OP_NONE, 8'hFF, 11'h7FF);
		issue(OP_READ, CH_NUL, 11'd0);
		issue(OP_READ, CH_NUL, 11'd1);
		issue(OP_READ, CH_NUL, 11'd2);
		issue(OP_READ, CH_NUL, 11'd80);
		issue(OP_CLEAR, 8'hFF, 11'h7FF);
		issue(OP_READ, CH_NUL, 11'd0);
		issue(OP_READ, CH_NUL, 11'd1999);
	endtask

	task automatic random_requests(int count);
		int                pick;
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [ADDR_W-1:0] addr;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 999);
			op   = OP_WRITE;
			ch   = CHAR_W'($urandom_range(0, 255));
			addr = ADDR_W'($urandom_range(0, CELL_COUNT - 1));
			if (text_run > 0) begin
				// long line of plain text so rows fill up and wrap
				ch = CHAR_W'($urandom_range(11, 255));
				text_run--;
			end else if (pick < 10)
				text_run = $urandom_range(40, 160);
			else if (pick < 12)
				op = OP_CLEAR;
			else if (pick < 30)
				op = OP_NONE;
			else if (pick < 170) begin
				op = OP_READ;
				case ($urandom_range(0, 9))
					0, 1, 2: addr = ADDR_W'(shadow.cursor > 0 ? shadow.cursor - 1 : 0);
					3:       addr = ADDR_W'($urandom_range(CELL_COUNT, 2047));
					4:       addr = ADDR_W'($urandom_range(CELL_COUNT - COLUMNS, CELL_COUNT - 1));
					default: ;
				endcase
			end else if (pick < 290)
				ch = CH_NEWLINE;
			else if (pick < 370)
				ch = CH_BACKSPACE;
			else if (pick < 385)
				ch = CH_NUL;
			issue(op, ch, addr);
		end
	endtask

	initial begin
		shadow       = new();
		arst_n       = 1'b0;
		start        = 1'b0;
		opcode       = '0;
		char_code    = '0;
		cell_address = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_requests();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       set_attribute(8'hFF);
				1:       set_attribute(8'h00);
				3:       set_attribute(8'h80);
				5:       set_attribute(RESET_ATTR);
				default: set_attribute(ATTR_W'($urandom));
			endcase
			random_requests(PHASE_ITEMS);
		end

		pause_requests();
		while (shadow.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		shadow.close();
		if (shadow.faults == 0)
			$display("[text_console_writer] OK");
		else
			$display("[text_console_writer] ERROR");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("[text_console_writer] ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_cursor.sv
rtl/tcw_sweep.sv
rtl/text_console_writer.sv
tb/tcw_tb_pkg.sv
tb/tb_text_console_writer.sv
